// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int POOL_BYTES = 2048;
   localparam int MIN_BLOCK  = 16;
   localparam int TOP_LEVEL  = 7;
   localparam int MIN_SHIFT  = $clog2(MIN_BLOCK);
   localparam int SLOT_COUNT = 1 << TOP_LEVEL;
   localparam int NODE_COUNT = (2 << TOP_LEVEL) - 1;
   localparam int SLOT_W     = TOP_LEVEL;
   localparam int NODE_W     = TOP_LEVEL + 1;
   localparam int LEVEL_W    = 3;
   localparam int TAG_W      = 4;
   localparam int HDR_W      = 7;
   localparam int BYTES_W    = 12;
   localparam logic [HDR_W-1:0] HDR_RESET = 7'd32;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_BAD_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      logic               operation;
      logic [BYTES_W-1:0] request_bytes;
      logic [BYTES_W-1:0] release_offset;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [BYTES_W-1:0] payload_offset;
      logic [LEVEL_W-1:0] block_level;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC_CHECK,
      ST_SEARCH,
      ST_SPLIT,
      ST_FREE_CHECK,
      ST_FREE_TAG,
      ST_MERGE
   } state_type;

   typedef enum logic [1:0] {
      RSP_ALLOC_OK,
      RSP_FREE_OK,
      RSP_FAIL
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         search;
      logic         split;
      logic         tag_read;
      logic         tag_take;
      logic         merge;
      logic         finish;
      rsp_kind_type kind;
      status_type   fail_status;
   } cmd_type;

   typedef struct packed {
      logic too_large;
      logic bad_addr;
      logic search_hit;
      logic at_top;
      logic split_done;
      logic tag_bad;
      logic merge_done;
   } stat_type;

   // tree node index of a block at a level and position
   function automatic logic [NODE_W-1:0] node_idx(input logic [LEVEL_W-1:0] level,
                                                  input logic [SLOT_W-1:0] pos);
      logic [NODE_W-1:0] base;
      base = (NODE_W'(1) << (LEVEL_W'(TOP_LEVEL) - level)) - NODE_W'(1);
      return base + NODE_W'(pos);
   endfunction

   // free bits of one level, position 0 at bit 0
   function automatic logic [SLOT_COUNT-1:0] level_vec(input logic [NODE_COUNT-1:0] free,
                                                       input logic [LEVEL_W-1:0] level);
      logic [SLOT_COUNT-1:0] v;
      v = '0;
      for (int l = 0; l <= TOP_LEVEL; l++) begin
         for (int p = 0; p < (1 << (TOP_LEVEL - l)); p++) begin
            if (level == LEVEL_W'(l)) begin
               v[p] = free[(1 << (TOP_LEVEL - l)) - 1 + p];
            end
         end
      end
      return v;
   endfunction

endpackage

// ----- rtl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate search and split, and for free check and merge.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_is_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bba_pkg::cmd_type  cmd,
   input  bba_pkg::stat_type stat
);

   bba_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic can_out;

   assign can_out   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // state and output slot registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.kind        = bba_pkg::RSP_FAIL;
      cmd.fail_status = bba_pkg::STATUS_OK;
      case (state_ff)
         bba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_is_free ? bba_pkg::ST_FREE_CHECK : bba_pkg::ST_ALLOC_CHECK;
            end
         end
         bba_pkg::ST_ALLOC_CHECK: begin
            if (!stat.too_large) begin
               state_in = bba_pkg::ST_SEARCH;
            end else if (can_out) begin
               cmd.finish      = 1'b1;
               cmd.fail_status = bba_pkg::STATUS_TOO_LARGE;
               state_in        = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_SEARCH: begin
            if (stat.search_hit) begin
               cmd.search = 1'b1;
               state_in   = bba_pkg::ST_SPLIT;
            end else if (!stat.at_top) begin
               cmd.search = 1'b1;
            end else if (can_out) begin
               cmd.finish      = 1'b1;
               cmd.fail_status = bba_pkg::STATUS_NO_SPACE;
               state_in        = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_SPLIT: begin
            if (!stat.split_done) begin
               cmd.split = 1'b1;
            end else if (can_out) begin
               cmd.finish = 1'b1;
               cmd.kind   = bba_pkg::RSP_ALLOC_OK;
               state_in   = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_FREE_CHECK: begin
            if (!stat.bad_addr) begin
               cmd.tag_read = 1'b1;
               state_in     = bba_pkg::ST_FREE_TAG;
            end else if (can_out) begin
               cmd.finish      = 1'b1;
               cmd.fail_status = bba_pkg::STATUS_BAD_FREE;
               state_in        = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_FREE_TAG: begin
            if (!stat.tag_bad) begin
               cmd.tag_take = 1'b1;
               state_in     = bba_pkg::ST_MERGE;
            end else if (can_out) begin
               cmd.finish      = 1'b1;
               cmd.fail_status = bba_pkg::STATUS_BAD_FREE;
               state_in        = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_MERGE: begin
            if (!stat.merge_done) begin
               cmd.merge = 1'b1;
            end else if (can_out) begin
               cmd.merge  = 1'b1;
               cmd.finish = 1'b1;
               cmd.kind   = bba_pkg::RSP_FREE_OK;
               state_in   = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   end

   // a result is only produced into a free or draining output slot
   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> can_out)
      else $error("result produced while output slot is full");

   // a new item is only taken with the sequencer idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == bba_pkg::ST_ALLOC_CHECK || state_ff == bba_pkg::ST_FREE_CHECK))
      else $error("load did not enter a check state");

   // a finished result is visible in the next cycle
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule

// ----- rtl/bba_datapath.sv -----
// ----------------------------------------------------------------------------
// bba_datapath
// Free tree bits, tag memory, level and position registers, result register.
// ----------------------------------------------------------------------------
module bba_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bba_pkg::HDR_W-1:0]       csr_write_data,
   input  bba_pkg::req_type                req_payload,
   output bba_pkg::rsp_type                rsp_payload,
   input  bba_pkg::cmd_type                cmd,
   output bba_pkg::stat_type               stat
);

   localparam int LW = bba_pkg::LEVEL_W;
   localparam int SW = bba_pkg::SLOT_W;
   localparam int BW = bba_pkg::BYTES_W;

   logic [bba_pkg::HDR_W-1:0]      hdr_ff;
   logic [bba_pkg::NODE_COUNT-1:0] free_ff, free_in;
   logic [bba_pkg::SLOT_COUNT-1:0] tag_valid_ff, tag_valid_in;
   logic                           tag_valid_rd_ff;
   logic [LW-1:0]                  want_ff, want_in, k_ff, k_in, freed_ff, freed_in;
   logic [SW-1:0]                  pos_ff, pos_in, slot_ff, slot_in;
   logic [BW-1:0]                  offset_ff, offset_in;
   logic                           too_large_ff, too_large_in, bad_addr_ff, bad_addr_in;
   bba_pkg::rsp_type               rsp_ff, rsp_in;

   logic [BW:0]                    total;
   logic [BW-1:0]                  block;
   logic [LW-1:0]                  want_calc;
   logic [bba_pkg::SLOT_COUNT-1:0] lvl_bits;
   logic                           hit;
   logic [SW-1:0]                  hit_pos;
   logic [SW-1:0]                  alloc_slot;
   logic [bba_pkg::TAG_W-1:0]      tag_rd;
   logic [LW-1:0]                  tag_level;
   logic [bba_pkg::NODE_W-1:0]     buddy_idx;
   logic                           can_merge;
   logic                           tag_we;

   // header register
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= bba_pkg::HDR_RESET;
      end else if (csr_write_enable) begin
         hdr_ff <= csr_write_data;
      end
   end

   // request decode: rounded level and free address check
   always_comb begin
      total     = {1'b0, req_payload.request_bytes} + (BW+1)'(hdr_ff);
      want_calc = LW'(bba_pkg::TOP_LEVEL);
      for (int l = bba_pkg::TOP_LEVEL; l >= 0; l--) begin
         if (total <= (BW+1)'(bba_pkg::MIN_BLOCK << l)) begin
            want_calc = LW'(l);
         end
      end
      block = req_payload.release_offset - BW'(hdr_ff);
   end

   // level search
   always_comb begin
      lvl_bits = bba_pkg::level_vec(free_ff, k_ff);
      hit      = |lvl_bits;
      hit_pos  = '0;
      for (int p = bba_pkg::SLOT_COUNT - 1; p >= 0; p--) begin
         if (lvl_bits[p]) begin
            hit_pos = SW'(p);
         end
      end
   end

   assign alloc_slot = pos_ff << want_ff;
   assign tag_level  = LW'(tag_rd - bba_pkg::TAG_W'(1));
   assign buddy_idx  = bba_pkg::node_idx(k_ff, pos_ff ^ SW'(1));
   assign can_merge  = (k_ff != LW'(bba_pkg::TOP_LEVEL)) && free_ff[buddy_idx];

   // status to the sequencer
   always_comb begin
      stat.too_large  = too_large_ff;
      stat.bad_addr   = bad_addr_ff;
      stat.search_hit = hit;
      stat.at_top     = (k_ff == LW'(bba_pkg::TOP_LEVEL));
      stat.split_done = (k_ff == want_ff);
      stat.tag_bad    = !tag_valid_rd_ff || (tag_rd == '0)
                        || (tag_rd > bba_pkg::TAG_W'(bba_pkg::TOP_LEVEL + 1));
      stat.merge_done = !can_merge;
   end

   // working register updates
   always_comb begin
      want_in      = want_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      offset_in    = offset_ff;
      freed_in     = freed_ff;
      too_large_in = too_large_ff;
      bad_addr_in  = bad_addr_ff;
      free_in      = free_ff;
      tag_valid_in = tag_valid_ff;
      rsp_in       = rsp_ff;
      tag_we       = 1'b0;
      if (cmd.load) begin
         want_in      = want_calc;
         k_in         = want_calc;
         too_large_in = total > (BW+1)'(bba_pkg::POOL_BYTES);
         offset_in    = req_payload.release_offset;
         slot_in      = block[bba_pkg::MIN_SHIFT +: SW];
         bad_addr_in  = (req_payload.release_offset < BW'(hdr_ff))
                        || (block[bba_pkg::MIN_SHIFT-1:0] != '0)
                        || (block >= BW'(bba_pkg::POOL_BYTES));
      end
      if (cmd.search) begin
         if (hit) begin
            pos_in = hit_pos;
            free_in[bba_pkg::node_idx(k_ff, hit_pos)] = 1'b0;
         end else begin
            k_in = k_ff + LW'(1);
         end
      end
      if (cmd.split) begin
         k_in   = k_ff - LW'(1);
         pos_in = pos_ff << 1;
         free_in[bba_pkg::node_idx(k_ff - LW'(1), (pos_ff << 1) | SW'(1))] = 1'b1;
      end
      if (cmd.tag_take) begin
         k_in     = tag_level;
         freed_in = tag_level;
         pos_in   = slot_ff >> tag_level;
         tag_valid_in[slot_ff] = 1'b0;
      end
      if (cmd.merge) begin
         if (can_merge) begin
            free_in[buddy_idx] = 1'b0;
            k_in   = k_ff + LW'(1);
            pos_in = pos_ff >> 1;
         end else begin
            free_in[bba_pkg::node_idx(k_ff, pos_ff)] = 1'b1;
         end
      end
      if (cmd.finish) begin
         case (cmd.kind)
            bba_pkg::RSP_ALLOC_OK: begin
               tag_we                   = 1'b1;
               tag_valid_in[alloc_slot] = 1'b1;
               rsp_in.status            = bba_pkg::STATUS_OK;
               rsp_in.payload_offset    = BW'({alloc_slot, {bba_pkg::MIN_SHIFT{1'b0}}})
                                          + BW'(hdr_ff);
               rsp_in.block_level       = want_ff;
            end
            bba_pkg::RSP_FREE_OK: begin
               rsp_in.status         = bba_pkg::STATUS_OK;
               rsp_in.payload_offset = offset_ff;
               rsp_in.block_level    = freed_ff;
            end
            default: begin
               rsp_in.status         = cmd.fail_status;
               rsp_in.payload_offset = '0;
               rsp_in.block_level    = '0;
            end
         endcase
      end
   end

   // control-like state: tree and tag valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= bba_pkg::NODE_COUNT'(1);
         tag_valid_ff <= '0;
      end else begin
         free_ff      <= free_in;
         tag_valid_ff <= tag_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      k_ff         <= k_in;
      pos_ff       <= pos_in;
      slot_ff      <= slot_in;
      offset_ff    <= offset_in;
      freed_ff     <= freed_in;
      too_large_ff <= too_large_in;
      bad_addr_ff  <= bad_addr_in;
      rsp_ff       <= rsp_in;
      if (cmd.tag_read) begin
         tag_valid_rd_ff <= tag_valid_ff[slot_ff];
      end
   end

   // per-slot level tags
   bba_ram #(
      .WIDTH(bba_pkg::TAG_W),
      .DEPTH(bba_pkg::SLOT_COUNT)
   ) u_tags (
      .clock        (clock),
      .write_enable (tag_we),
      .write_address(alloc_slot),
      .write_data   (bba_pkg::TAG_W'(want_ff) + bba_pkg::TAG_W'(1)),
      .read_enable  (cmd.tag_read),
      .read_address (slot_ff),
      .read_data    (tag_rd)
   );

   assign rsp_payload = rsp_ff;

   // splitting never goes below the wanted level
   a_split_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.split |-> (k_ff > want_ff))
      else $error("split below wanted level");

   // an allocate starts its search at the wanted level
   a_load_level: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (k_ff == want_ff))
      else $error("search level not initialized");

   // a granted block leaves its slot tagged
   a_alloc_tag: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && cmd.kind == bba_pkg::RSP_ALLOC_OK) |=> tag_valid_ff[$past(alloc_slot)])
      else $error("granted block has no tag");

endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a 2048-byte pool, 16-byte to 2048-byte blocks.
// ----------------------------------------------------------------------------
// req channel carries one item: an allocate (byte count) or a free (payload
// offset). rsp channel returns exactly one item per request: status, payload
// offset and block level. csr_write_enable loads the header byte count; write
// it only while no item is in flight.
// One item is worked on at a time. An allocate searches upward from the wanted
// level for a free block and then splits it down to the wanted level; a free
// checks the offset, reads the slot's tag and merges with free buddies upward.
// A rejected item (too large, no space, bad free) returns a fail status.
// The search, split and merge walk move one level per cycle, and the tag
// memory is read through a registered port.
// The result sits in an output register; a new item is taken while it waits,
// and the sequencer holds before producing the next result until the
// receiver takes the old one.
// Reset (synchronous) marks only the whole pool free, clears all tags and
// sets the header byte count to 32; no clearing pass is needed.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bba_pkg::HDR_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bba_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bba_pkg::rsp_type              rsp_payload
);

   bba_pkg::cmd_type  cmd;
   bba_pkg::stat_type stat;

   // sequencer
   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_is_free(req_payload.operation == bba_pkg::OP_FREE),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // tree, tags and result
   bba_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_payload     (req_payload),
      .rsp_payload     (rsp_payload),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule
